// File: design/rvpf_pkg.sv
`timescale 1ns / 1ps
// Package for the radial vignette pixel filter: sizes, mode and register codes,
// and the record that travels down the divider chain. No dependencies.
package rvpf_pkg;

  // Largest frame dimension; larger register values saturate to it.
  localparam int unsigned MaxDim = 4096;

  localparam int unsigned DimW   = 13;  // width/height register
  localparam int unsigned CoordW = 12;  // column/row
  localparam int unsigned ChanW  = 8;   // one color channel
  localparam int unsigned ModeW  = 2;
  localparam int unsigned Lanes  = 4;   // blue, green, red, alpha

  localparam int unsigned LaneBlue  = 0;
  localparam int unsigned LaneGreen = 1;
  localparam int unsigned LaneRed   = 2;
  localparam int unsigned LaneAlpha = 3;

  // Squared distance and 4*d
  localparam int unsigned SqW    = 2 * CoordW;
  localparam int unsigned FourDW = SqW + 3;

  // S = w^2 + h^2 with w, h at most MaxDim (and at most what the register holds)
  localparam longint unsigned DimCap = (longint'(MaxDim) < (longint'(1) << DimW)) ?
                                       longint'(MaxDim) : ((longint'(1) << DimW) - 1);
  localparam longint unsigned SMax   = 2 * DimCap * DimCap;
  localparam int unsigned     SW     = $clog2(SMax + 1);
  localparam int unsigned     CmpW   = (FourDW > SW) ? FourDW : SW;

  // Dividend c*(S-4d) and the shifted divisor share this width
  localparam int unsigned NW = SW + ChanW;

  // One divider cell per quotient bit
  localparam int unsigned Cells = ChanW;

  // Register indexes
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMode   = 2'd2;

  // Mode codes
  localparam logic [ModeW-1:0] ModeNone   = 2'd0;
  localparam logic [ModeW-1:0] ModeShadow = 2'd1;
  localparam logic [ModeW-1:0] ModeFade   = 2'd2;
  localparam logic [ModeW-1:0] ModeAlpha  = 2'd3;

  localparam logic [ChanW-1:0] BlendAlpha = 8'd150;

  localparam logic [DimW-1:0] DimReset = 13'd64;

  typedef logic [Lanes-1:0][ChanW-1:0] pix_t;

  typedef struct packed {
    logic [Lanes-1:0][NW-1:0] rem;
    pix_t                     quo;
    logic [NW-1:0]            div;
    pix_t                     pix;
  } cell_t;

endpackage

// File: design/radial_vignette_pixel_filter_unit.sv
`timescale 1ns / 1ps
// Top level of the radial vignette pixel filter: configuration registers,
// geometry front end, chain of divider cells and output register.
// Depends on rvpf_pkg, rvpf_geom and rvpf_div_cell.
//
// The unit takes one BGRA pixel with its column and row per transaction and
// returns one filtered pixel per transaction, one pixel per clock whenever the result is taken.
// With cx = width/2, cy = height/2 (floored), d = (column-cx)^2 + (row-cy)^2
// and S = width^2 + height^2, a scaled channel c becomes floor(c*(S-4d)/S),
// and 0 wherever 4d >= S. Mode 0 passes the pixel through, mode 1 darkens
// red, green and blue, mode 2 fades alpha, mode 3 forces alpha to 150.
// Width and height above the package maximum saturate to it. The pipeline is
// made of four front stages (offset, squares, clip, dividend multiply), one
// cell per quotient bit of the exact division by S (eight cells), and the
// output register. Every stage holds one transaction and advances when the
// stage after it is free, so a stalled result only backs up the chain once
// all stages are full. Write the registers only while no transaction is in
// flight; S is re-registered from width and height every cycle, so a write
// reaches it through the configuration register and then s_reg.
module radial_vignette_pixel_filter_unit (
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        wr_en,
  input  logic [1:0]                  wr_index,
  input  logic [rvpf_pkg::DimW-1:0]   wr_data,
  // pixel channel
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  logic [rvpf_pkg::CoordW-1:0] column,
  input  logic [rvpf_pkg::CoordW-1:0] row,
  input  logic [rvpf_pkg::ChanW-1:0]  blue_in,
  input  logic [rvpf_pkg::ChanW-1:0]  green_in,
  input  logic [rvpf_pkg::ChanW-1:0]  red_in,
  input  logic [rvpf_pkg::ChanW-1:0]  alpha_in,
  // result channel
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [rvpf_pkg::ChanW-1:0]  blue_out,
  output logic [rvpf_pkg::ChanW-1:0]  green_out,
  output logic [rvpf_pkg::ChanW-1:0]  red_out,
  output logic [rvpf_pkg::ChanW-1:0]  alpha_out
);

  logic [rvpf_pkg::DimW-1:0]  width_reg, height_reg;
  logic [rvpf_pkg::ModeW-1:0] mode_reg;
  logic [rvpf_pkg::DimW-1:0]  w_clamp, h_clamp;
  logic [rvpf_pkg::SW-1:0]    s_reg;
  logic [2*rvpf_pkg::DimW:0]  s_full;
  logic [rvpf_pkg::CoordW-1:0] cx, cy;

  rvpf_pkg::pix_t  pix_in;
  rvpf_pkg::pix_t  pix_sel;

  logic            chain_valid [rvpf_pkg::Cells+1];
  logic            chain_ready [rvpf_pkg::Cells+1];
  rvpf_pkg::cell_t chain_data  [rvpf_pkg::Cells+1];

  logic            out_stage_ready;
  rvpf_pkg::cell_t last;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= rvpf_pkg::DimReset;
      height_reg <= rvpf_pkg::DimReset;
      mode_reg   <= rvpf_pkg::ModeNone;
    end else if (wr_en) begin
      case (wr_index)
        rvpf_pkg::RegWidth:  width_reg  <= wr_data;
        rvpf_pkg::RegHeight: height_reg <= wr_data;
        rvpf_pkg::RegMode:   mode_reg   <= wr_data[rvpf_pkg::ModeW-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Saturate oversized dimensions
  assign w_clamp = (32'(width_reg) > rvpf_pkg::MaxDim) ?
                   rvpf_pkg::DimW'(rvpf_pkg::MaxDim) : width_reg;
  assign h_clamp = (32'(height_reg) > rvpf_pkg::MaxDim) ?
                   rvpf_pkg::DimW'(rvpf_pkg::MaxDim) : height_reg;

  assign cx = rvpf_pkg::CoordW'(w_clamp >> 1);
  assign cy = rvpf_pkg::CoordW'(h_clamp >> 1);

  // Refresh S every cycle; it only moves after a configuration write
  assign s_full = (2*rvpf_pkg::DimW+1)'(w_clamp) * (2*rvpf_pkg::DimW+1)'(w_clamp) +
                  (2*rvpf_pkg::DimW+1)'(h_clamp) * (2*rvpf_pkg::DimW+1)'(h_clamp);

  always_ff @(posedge clk) begin
    s_reg <= rvpf_pkg::SW'(s_full);
  end

  // ---------------------------------------------------------------------------
  // Geometry front end
  // ---------------------------------------------------------------------------
  always_comb begin
    pix_in[rvpf_pkg::LaneBlue]  = blue_in;
    pix_in[rvpf_pkg::LaneGreen] = green_in;
    pix_in[rvpf_pkg::LaneRed]   = red_in;
    pix_in[rvpf_pkg::LaneAlpha] = alpha_in;
  end

  rvpf_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_valid),
    .in_ready  (pixel_ready),
    .column    (column),
    .row       (row),
    .pix       (pix_in),
    .cx        (cx),
    .cy        (cy),
    .s         (s_reg),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  // ---------------------------------------------------------------------------
  // Divider chain: one cell per quotient bit, MSB first
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < rvpf_pkg::Cells; i++) begin : g_cell
    rvpf_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: pick scaled or original channels by mode
  // ---------------------------------------------------------------------------
  assign last                         = chain_data[rvpf_pkg::Cells];
  assign out_stage_ready              = !result_valid || result_ready;
  assign chain_ready[rvpf_pkg::Cells] = out_stage_ready;

  always_comb begin
    pix_sel = last.pix;
    case (mode_reg)
      rvpf_pkg::ModeShadow: begin
        pix_sel[rvpf_pkg::LaneBlue]  = last.quo[rvpf_pkg::LaneBlue];
        pix_sel[rvpf_pkg::LaneGreen] = last.quo[rvpf_pkg::LaneGreen];
        pix_sel[rvpf_pkg::LaneRed]   = last.quo[rvpf_pkg::LaneRed];
      end
      rvpf_pkg::ModeFade: begin
        pix_sel[rvpf_pkg::LaneAlpha] = last.quo[rvpf_pkg::LaneAlpha];
      end
      rvpf_pkg::ModeAlpha: begin
        pix_sel[rvpf_pkg::LaneAlpha] = rvpf_pkg::BlendAlpha;
      end
      default: begin
        pix_sel = last.pix;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_stage_ready) begin
      result_valid <= chain_valid[rvpf_pkg::Cells];
    end
  end

  always_ff @(posedge clk) begin
    if (out_stage_ready && chain_valid[rvpf_pkg::Cells]) begin
      blue_out  <= pix_sel[rvpf_pkg::LaneBlue];
      green_out <= pix_sel[rvpf_pkg::LaneGreen];
      red_out   <= pix_sel[rvpf_pkg::LaneRed];
      alpha_out <= pix_sel[rvpf_pkg::LaneAlpha];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // input backs up only when the whole chain is full behind a stalled result
  assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> (result_valid && !result_ready && chain_valid[rvpf_pkg::Cells]))
    else $error("pixel input stalled without a stalled result");

  // a factor of at most one never brightens a channel
  assert property (@(posedge clk) disable iff (rst)
    chain_valid[rvpf_pkg::Cells] |->
      (last.quo[0] <= last.pix[0]) && (last.quo[1] <= last.pix[1]) &&
      (last.quo[2] <= last.pix[2]) && (last.quo[3] <= last.pix[3]))
    else $error("scaled channel exceeds original");

endmodule

// File: design/rvpf_geom.sv
`timescale 1ns / 1ps
// Front of the filter: distance from the frame center, clipped factor numerator
// S-4d and the per-lane dividends. Depends on rvpf_pkg.
module rvpf_geom (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rvpf_pkg::CoordW-1:0] column,
  input  logic [rvpf_pkg::CoordW-1:0] row,
  input  rvpf_pkg::pix_t              pix,
  input  logic [rvpf_pkg::CoordW-1:0] cx,
  input  logic [rvpf_pkg::CoordW-1:0] cy,
  input  logic [rvpf_pkg::SW-1:0]     s,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rvpf_pkg::cell_t             out_data
);

  logic [3:0] vld;
  logic [4:0] rdy;

  logic [rvpf_pkg::CoordW-1:0] dx, dy, dx_next, dy_next;
  logic [rvpf_pkg::SqW-1:0]    dx2, dy2;
  logic [rvpf_pkg::SW-1:0]     num, num_next;
  rvpf_pkg::pix_t              p0, p1, p2;
  rvpf_pkg::cell_t             g3, g3_next;

  logic [rvpf_pkg::SqW:0]      sum;
  logic [rvpf_pkg::CmpW-1:0]   fd_ext, s_ext;

  always_comb begin
    rdy[4] = out_ready;
    for (int i = 3; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[3];
  assign out_data  = g3;

  assign dx_next = (column >= cx) ? (column - cx) : (cx - column);
  assign dy_next = (row >= cy) ? (row - cy) : (cy - row);

  always_comb begin
    sum    = (rvpf_pkg::SqW+1)'(dx2) + (rvpf_pkg::SqW+1)'(dy2);
    fd_ext = rvpf_pkg::CmpW'({sum, 2'b00});
    s_ext  = rvpf_pkg::CmpW'(s);
    // outside the circle the factor is zero
    num_next = (fd_ext >= s_ext) ? '0 : rvpf_pkg::SW'(s_ext - fd_ext);
  end

  always_comb begin
    for (int k = 0; k < rvpf_pkg::Lanes; k++) begin
      g3_next.rem[k] = rvpf_pkg::NW'(p2[k]) * rvpf_pkg::NW'(num);
    end
    g3_next.quo = '0;
    g3_next.div = rvpf_pkg::NW'(s) << (rvpf_pkg::Cells - 1);
    g3_next.pix = p2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < 4; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      dx <= dx_next;
      dy <= dy_next;
      p0 <= pix;
    end
    if (rdy[1] && vld[0]) begin
      dx2 <= rvpf_pkg::SqW'(dx) * rvpf_pkg::SqW'(dx);
      dy2 <= rvpf_pkg::SqW'(dy) * rvpf_pkg::SqW'(dy);
      p1  <= p0;
    end
    if (rdy[2] && vld[1]) begin
      num <= num_next;
      p2  <= p1;
    end
    if (rdy[3] && vld[2]) begin
      g3 <= g3_next;
    end
  end

endmodule

// File: design/rvpf_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: resolves one quotient bit for every lane and
// hands the halved divisor to its neighbor. Depends on rvpf_pkg.
module rvpf_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rvpf_pkg::cell_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output rvpf_pkg::cell_t out_data
);

  rvpf_pkg::cell_t data, data_next;
  logic            valid;

  // a zero divisor (zero width and height) resolves every bit to zero
  always_comb begin
    data_next     = in_data;
    data_next.div = in_data.div >> 1;
    for (int k = 0; k < rvpf_pkg::Lanes; k++) begin
      if ((in_data.div != '0) && (in_data.rem[k] >= in_data.div)) begin
        data_next.rem[k] = in_data.rem[k] - in_data.div;
        data_next.quo[k] = {in_data.quo[k][rvpf_pkg::ChanW-2:0], 1'b1};
      end else begin
        data_next.quo[k] = {in_data.quo[k][rvpf_pkg::ChanW-2:0], 1'b0};
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  // remainder never exceeds twice the divisor that the next cell will use
  assert property (@(posedge clk) disable iff (rst)
    valid |-> ((rvpf_pkg::NW+1)'(data.rem[0]) <= {data.div, 1'b0}) &&
              ((rvpf_pkg::NW+1)'(data.rem[1]) <= {data.div, 1'b0}) &&
              ((rvpf_pkg::NW+1)'(data.rem[2]) <= {data.div, 1'b0}) &&
              ((rvpf_pkg::NW+1)'(data.rem[3]) <= {data.div, 1'b0}))
    else $error("divider remainder out of range");

endmodule
